/* design/fdec_pkg.sv */
`timescale 1ns / 1ps
package fdec_pkg;

  localparam int TAP_COUNT   = 15;
  localparam int DECIMATION  = 3;
  localparam int TAP_W       = $clog2(TAP_COUNT);
  localparam int PHASE_W     = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 16;
  localparam int COEF_W      = 16;
  localparam int ACC_W       = 32;
  localparam int PROD_W      = ACC_W + GAIN_W + 1;
  localparam int FRAC_SHIFT  = 27;
  localparam int QUOT_W      = PROD_W - FRAC_SHIFT;
  localparam int COEF_LEN    = 15;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [GAIN_W-1:0]   GAIN_RESET = 16'd4096;
  localparam logic [SAMPLE_W-1:0] SAT_MAX    = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] SAT_MIN    = 16'h8000;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic                       decimate;
    logic signed [SAMPLE_W-1:0] sample;
  } job_t;

  localparam coef_t COEF_TABLE [COEF_LEN] = '{
    16'sd102,  16'sd0,    -16'sd452, -16'sd980, 16'sd0,
    16'sd3713, 16'sd8572, 16'sd10863, 16'sd8572, 16'sd3713,
    16'sd0,    -16'sd980, -16'sd452,  16'sd0,    16'sd102
  };

  function automatic coef_t coef_at(input logic [TAP_W-1:0] j);
    logic [5:0] idx;
    idx = 6'(j);
    if (idx < 6'(COEF_LEN)) begin
      coef_at = COEF_TABLE[idx[3:0]];
    end else begin
      coef_at = '0;
    end
  endfunction

endpackage

/* design/fdec_front.sv */
`timescale 1ns / 1ps
module fdec_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [fdec_pkg::SAMPLE_W-1:0] sample,
  input  logic                             queue_full,
  output logic                             push,
  output fdec_pkg::job_t                   push_job
);
  import fdec_pkg::*;

  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;

  assign in_stall          = queue_full;
  assign push              = in_valid && !queue_full;
  assign push_job.sample   = sample;
  assign push_job.decimate = (phase == '0);

  assign phase_next = (phase == PHASE_W'(DECIMATION - 1)) ? '0 : phase + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (push) begin
      phase <= phase_next;
    end
  end

endmodule

/* design/fdec_queue.sv */
`timescale 1ns / 1ps
module fdec_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fdec_pkg::job_t push_job,
  output logic           full,
  output logic           head_valid,
  output fdec_pkg::job_t head_job,
  input  logic           pop
);
  import fdec_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/fdec_back.sv */
`timescale 1ns / 1ps
module fdec_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  head_valid,
  input  fdec_pkg::job_t                        head_job,
  output logic                                  pop,
  input  logic [fdec_pkg::GAIN_W-1:0]           gain_level,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [fdec_pkg::SAMPLE_W-1:0]  filtered_sample
);
  import fdec_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAC  = 4'b0010,
    ST_PROD = 4'b0100,
    ST_SAT  = 4'b1000
  } back_state_t;

  back_state_t                state;
  logic signed [SAMPLE_W-1:0] hist [TAP_COUNT];
  logic [TAP_W-1:0]           wr_pos;
  logic [TAP_W-1:0]           rd_pos;
  logic [TAP_W-1:0]           tap;
  logic signed [ACC_W-1:0]    acc;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    mac_prod;
  logic signed [SAMPLE_W-1:0] hist_rd;
  coef_t                      coef_rd;
  logic [PROD_W-1:0]          prod_u;
  logic [PROD_W-1:0]          mag;
  logic [QUOT_W-1:0]          quot;
  logic [SAMPLE_W-1:0]        quot_lo;
  logic                       neg;
  logic [SAMPLE_W-1:0]        sat_value;
  logic                       out_free;

  assign pop      = (state == ST_IDLE) && head_valid;
  assign out_free = !out_valid || !out_stall;

  assign hist_rd  = hist[rd_pos];
  assign coef_rd  = coef_at(tap);
  assign mac_prod = hist_rd * coef_rd;

  assign prod_u  = prod;
  assign neg     = prod[PROD_W-1];
  assign mag     = neg ? (~prod_u + 1'b1) : prod_u;
  assign quot    = mag[PROD_W-1:FRAC_SHIFT];
  assign quot_lo = quot[SAMPLE_W-1:0];

  always_comb begin
    if (neg) begin
      sat_value = (quot > QUOT_W'(32768)) ? SAT_MIN : (~quot_lo + 1'b1);
    end else begin
      sat_value = (quot > QUOT_W'(32767)) ? SAT_MAX : quot_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wr_pos    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < TAP_COUNT; i++) begin
        hist[i] <= '0;
      end
    end else begin
      if ((state == ST_SAT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (head_valid) begin
            hist[wr_pos] <= head_job.sample;
            wr_pos <= (wr_pos == TAP_W'(TAP_COUNT - 1)) ? '0 : wr_pos + 1'b1;
            if (head_job.decimate) begin
              rd_pos <= wr_pos;
              tap    <= '0;
              acc    <= '0;
              state  <= ST_MAC;
            end
          end
        end
        ST_MAC: begin
          acc    <= acc + mac_prod;
          rd_pos <= (rd_pos == '0) ? TAP_W'(TAP_COUNT - 1) : rd_pos - 1'b1;
          tap    <= tap + 1'b1;
          if (tap == TAP_W'(TAP_COUNT - 1)) begin
            state <= ST_PROD;
          end
        end
        ST_PROD: begin
          prod  <= acc * $signed({1'b0, gain_level});
          state <= ST_SAT;
        end
        ST_SAT: begin
          if (out_free) begin
            filtered_sample <= sat_value;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/fir_decimator_by_three.sv */
// Every third sample starts a result; the single multiply-accumulate unit walks 15 taps
// one per cycle, then the gain product is formed and saturated into the output register.
// That register is loaded only while it is empty or its result is being taken.
// A 2-entry queue between intake and filter lets two samples be taken while it works.
// Reset (rst, synchronous, active high) clears history, ring position, phase and
// queue, empties the output, and sets gain to unity (4096).
`timescale 1ns / 1ps
module fir_decimator_by_three (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [fdec_pkg::SAMPLE_W-1:0] sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [fdec_pkg::SAMPLE_W-1:0] filtered_sample,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fdec_pkg::GAIN_W-1:0]          gain
);
  import fdec_pkg::*;

  logic              gain_level_q;
  logic [GAIN_W-1:0] gain_level;
  logic              push;
  job_t              push_job;
  logic              queue_full;
  logic              head_valid;
  job_t              head_job;
  logic              pop;

  assign cfg_ready    = 1'b1;
  assign gain_level_q = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_level <= GAIN_RESET;
    end else if (gain_level_q) begin
      gain_level <= gain;
    end
  end

  fdec_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  fdec_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  fdec_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (head_valid),
    .head_job        (head_job),
    .pop             (pop),
    .gain_level      (gain_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .filtered_sample (filtered_sample)
  );

endmodule

/* design/fdec_checker.sv */
`timescale 1ns / 1ps
module fdec_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [fdec_pkg::SAMPLE_W-1:0] filtered_sample
);
  import fdec_pkg::*;

  logic seen_input;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_input <= 1'b0;
    end else if (in_valid && !in_stall) begin
      seen_input <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(filtered_sample))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset did not clear the channels");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> seen_input)
    else $error("result without any input transfer");

endmodule

bind fir_decimator_by_three fdec_checker u_fdec_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .filtered_sample (filtered_sample)
);

/* tb/fdec_board_pkg.sv */
`timescale 1ns / 1ps
package fdec_board_pkg;
  import fdec_pkg::*;

  localparam int LOWPASS_Q15 [15] = '{
    102, 0, -452, -980, 0, 3713, 8572, 10863, 8572, 3713, 0, -980, -452, 0, 102
  };

  class decimated_output_board;
    logic signed [SAMPLE_W-1:0] history [TAP_COUNT];
    int unsigned ring_pos;
    int unsigned phase;
    logic [GAIN_W-1:0] gain_q412;
    logic signed [SAMPLE_W-1:0] expected_q [$];
    int unsigned mismatches;

    function new();
      foreach (history[i]) history[i] = '0;
      ring_pos = 0;
      phase = 0;
      gain_q412 = GAIN_RESET;
      mismatches = 0;
    endfunction

    function void set_gain(input logic [GAIN_W-1:0] g);
      gain_q412 = g;
    endfunction

    function logic signed [SAMPLE_W-1:0] scale_gain(input longint acc);
      longint prod;
      longint unsigned mag;
      longint unsigned q;
      longint r;
      prod = acc * longint'({48'd0, gain_q412});
      mag = (prod < 0) ? longint'(-prod) : prod;
      q = mag >> FRAC_SHIFT;
      if (prod < 0) begin
        r = (q > 64'd32768) ? -64'sd32768 : -longint'(q);
      end else begin
        r = (q > 64'd32767) ? 64'sd32767 : longint'(q);
      end
      return SAMPLE_W'(r);
    endfunction

    function void take_sample(input logic signed [SAMPLE_W-1:0] s);
      longint acc;
      int unsigned idx;
      int coef;
      history[ring_pos] = s;
      if (phase == 0) begin
        acc = 0;
        for (int j = 0; j < TAP_COUNT; j++) begin
          idx = (ring_pos + TAP_COUNT - j) % TAP_COUNT;
          coef = (j < 15) ? LOWPASS_Q15[j] : 0;
          acc += longint'(history[idx]) * longint'(coef);
        end
        expected_q = {expected_q, scale_gain(acc)};
      end
      ring_pos = (ring_pos + 1) % TAP_COUNT;
      phase = (phase + 1) % DECIMATION;
    endfunction

    function void check_output(input logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (expected_q.size() == 0) begin
        $display("%0t: filtered_sample %0d with nothing expected", $time, got);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          $display("%0t: filtered_sample expected %0d, got %0d", $time, want, got);
          mismatches++;
        end
      end
    endfunction

    function int unsigned waiting();
      return expected_q.size();
    endfunction
  endclass

endpackage

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import fdec_pkg::*;
  import fdec_board_pkg::*;

  localparam int SETTLE_CYCLES = 30;
  localparam int PHASE_ITEMS   = 285;
  localparam int PHASES        = 7;
  localparam int LONG_HOLD     = 300;

  localparam logic signed [SAMPLE_W-1:0] EDGE_SAMPLES [10] = '{
    16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
    16'sh7FFF, -16'sd1, 16'sd1, 16'sd0, 16'sh5555
  };

  typedef enum int {MIX_RANDOM, MIX_SMALL, MIX_EXTREME, MIX_RUN} sample_mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] filtered_sample;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [GAIN_W-1:0] cfg_gain = GAIN_RESET;

  decimated_output_board board = new();
  int unsigned burst_left = 0;
  int unsigned holds_asked = 0;
  sample_mix_t mix = MIX_RANDOM;
  int unsigned mix_left = 0;
  logic signed [SAMPLE_W-1:0] run_value = '0;

  fir_decimator_by_three u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .sample          (sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .filtered_sample (filtered_sample),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .gain            (cfg_gain)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_output(filtered_sample);
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] extreme_sample();
    case ($urandom_range(0, 4))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2: return -16'sd1;
      3: return 16'sd0;
      default: return 16'sd1;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    if (mix_left == 0) begin
      r = $urandom_range(0, 5);
      mix = (r < 2) ? MIX_RANDOM : sample_mix_t'(r - 2);
      mix_left = $urandom_range(1, 30);
      run_value = ($urandom_range(0, 1) == 0) ? extreme_sample() : SAMPLE_W'($urandom);
    end
    mix_left--;
    case (mix)
      MIX_SMALL: return SAMPLE_W'(int'($urandom_range(0, 255)) - 128);
      MIX_EXTREME: return extreme_sample();
      MIX_RUN: return run_value;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    sample = s;
    do @(posedge clk); while (in_stall);
    board.take_sample(s);
    burst_left--;
  endtask

  task automatic drain_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] g);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_gain = g;
    do @(posedge clk); while (!cfg_ready);
    board.set_gain(g);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    int unsigned span;
    int unsigned level;
    int unsigned holds_done;
    holds_done = 0;
    while (rst) @(negedge clk);
    forever begin
      if (holds_done != holds_asked || $urandom_range(0, 99) == 0) begin
        if (holds_done != holds_asked) holds_done++;
        @(negedge clk);
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        span = $urandom_range(1, 60);
        level = $urandom_range(0, 3);
        repeat (span) begin
          @(negedge clk);
          out_stall = ($urandom_range(0, 9) < level * 3);
        end
      end
    end
  end

  initial begin
    logic [GAIN_W-1:0] phase_gain;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < TAP_COUNT; i++) begin
      send_sample((i == 0) ? SAT_MAX : 16'sd0);
    end
    foreach (EDGE_SAMPLES[i]) send_sample(EDGE_SAMPLES[i]);
    drain_block();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: phase_gain = '0;
        1: phase_gain = '1;
        2: phase_gain = 16'd1;
        4: phase_gain = GAIN_RESET;
        5: phase_gain = 16'd8192;
        default: phase_gain = GAIN_W'($urandom);
      endcase
      write_gain(phase_gain);
      if (p == 1) holds_asked++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(pick_sample());
        if (n == PHASE_ITEMS / 2) drain_block();
      end
      drain_block();
    end

    if (board.mismatches == 0 && board.waiting() == 0) begin
      $display("tb_top: PASS");
    end else begin
      if (board.waiting() != 0) begin
        $display("%0t: %0d filtered samples never arrived", $time, board.waiting());
      end
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

/* files.f */
design/fdec_pkg.sv
design/fdec_front.sv
design/fdec_queue.sv
design/fdec_back.sv
design/fir_decimator_by_three.sv
design/fdec_checker.sv
tb/fdec_board_pkg.sv
tb/tb_top.sv
